/* rtl/bra_pkg.sv */
`default_nettype none
package bra_pkg;

  localparam int STORE_BYTES = 128;
  localparam logic [7:0] RESET_BYTES = 8'd128;

  localparam logic [1:0] CMD_TEST  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_SCAN  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_SAME      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  bit_index;
    logic [10:0] run_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  result_index;
    logic        bit_value;
    logic [10:0] free_count;
  } rsp_t;

  // outcome of walking one bitmap byte
  typedef struct packed {
    logic        run_found;
    logic [2:0]  run_pos;
    logic [10:0] run_out;
    logic        zero_found;
    logic [2:0]  zero_pos;
  } byte_res_t;

endpackage
`default_nettype wire

/* rtl/bra_ram.sv */
`default_nettype none
module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                      wdata,
  output      logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* rtl/bra_byte_unit.sv */
`default_nettype none
module bra_byte_unit (
  input  wire logic [7:0]  data,
  input  wire logic [10:0] run_in,
  input  wire logic [10:0] run_length,
  output bra_pkg::byte_res_t res
);

  logic [10:0] r;
  logic        found;
  logic [2:0]  pos;
  logic        zf;
  logic [2:0]  zp;

  // walk the eight bits low to high, extending the current free run
  always_comb begin
    r     = run_in;
    found = 1'b0;
    pos   = 3'd0;
    zf    = 1'b0;
    zp    = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (!data[k]) begin
        r = r + 11'd1;
        if (!found && (r == run_length)) begin
          found = 1'b1;
          pos   = 3'(k);
        end
        if (!zf) begin
          zf = 1'b1;
          zp = 3'(k);
        end
      end else begin
        r = 11'd0;
      end
    end
    res.run_found  = found;
    res.run_pos    = pos;
    res.run_out    = r;
    res.zero_found = zf;
    res.zero_pos   = zp;
  end

endmodule
`default_nettype wire

/* rtl/bitmap_run_allocator.sv */
`default_nettype none
// channel  | dir | handshake              | payload
// ---------+-----+------------------------+--------------------------
// req      | in  | req_valid / req_ready  | bra_pkg::req_t
// rsp      | out | rsp_valid / rsp_ready  | bra_pkg::rsp_t
// cfg      | in  | cfg_valid / cfg_ready  | cfg_data, byte count
//
// test and clear pass through the op state to done; out-of-range requests and early
// scan misses go straight to done; set seeks a new lowest free bit when it moves
// scan walks the bytes from the one holding lowest_free up to used bytes; the bitmap ram
//   delivers one byte per cycle to the shared byte unit
// reset and cfg writes clear the bitmap at once through per-byte valid flags
// a finished result waits in the output register; the next request is
//   taken and worked on meanwhile, only its hand-off waits
module bitmap_run_allocator #(
  parameter int MAX_BYTES = 128
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output      logic           req_ready,
  input  wire bra_pkg::req_t  req_data,
  output      logic           rsp_valid,
  input  wire logic           rsp_ready,
  output      bra_pkg::rsp_t  rsp_data,
  input  wire logic           cfg_valid,
  output      logic           cfg_ready,
  input  wire logic [7:0]     cfg_data
);

  localparam int DEPTH = (MAX_BYTES < bra_pkg::STORE_BYTES) ? MAX_BYTES
                                                            : bra_pkg::STORE_BYTES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [7:0] CAP_B = 8'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OP   = 5'b00010,
    S_SEEK = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  function automatic logic [7:0] eff_bytes(input logic [7:0] v);
    logic [7:0] n;
    n = v;
    if (n == 8'd0) n = 8'd1;
    if (n > CAP_B) n = CAP_B;
    return n;
  endfunction

  state_t      state;
  logic [7:0]  byte_count;
  logic [10:0] lowest_free;
  logic [10:0] free_total;
  logic [DEPTH-1:0] vld;
  logic        vld_q;

  logic [1:0]  cmd_q;
  logic [9:0]  idx_q;
  logic [10:0] len_q;
  logic [7:0]  ptr;
  logic [7:0]  pbyte;
  logic        pvalid;
  logic [10:0] run;

  logic [1:0]  res_status;
  logic [9:0]  res_index;
  logic        res_bval;

  logic [7:0]  used;
  logic [10:0] nbits;
  logic [AW-1:0] ram_addr;
  logic        ram_we;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;
  logic [7:0]  cur_byte;
  logic        cur_bit;
  logic [7:0]  bit_mask;
  logic [10:0] idx_inc;
  logic [11:0] scan_start;
  logic        walk_end;
  bra_pkg::byte_res_t bres;

  assign used      = eff_bytes(byte_count);
  assign nbits     = {used, 3'b000};
  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign cur_byte   = vld_q ? ram_rdata : 8'h00;
  assign cur_bit    = cur_byte[idx_q[2:0]];
  assign bit_mask   = 8'h01 << idx_q[2:0];
  assign idx_inc    = {1'b0, idx_q} + 11'd1;
  assign scan_start = {1'b0, pbyte, 3'b000} + {9'd0, bres.run_pos} + 12'd1
                      - {1'b0, len_q};
  assign walk_end   = !pvalid && (ptr >= used);

  always_comb begin
    ram_addr  = AW'(ptr);
    ram_we    = 1'b0;
    ram_wdata = cur_byte | bit_mask;
    case (state)
      S_IDLE: begin
        if (req_data.cmd == bra_pkg::CMD_SCAN) begin
          ram_addr = AW'(lowest_free[10:3]);
        end else begin
          ram_addr = AW'(req_data.bit_index[9:3]);
        end
      end
      S_OP: begin
        ram_addr = AW'(idx_q[9:3]);
        if (cmd_q == bra_pkg::CMD_SET && !cur_bit) begin
          ram_we = 1'b1;
        end else if (cmd_q == bra_pkg::CMD_CLEAR && cur_bit) begin
          ram_we    = 1'b1;
          ram_wdata = cur_byte & ~bit_mask;
        end
      end
      default: ram_addr = AW'(ptr);
    endcase
  end

  bra_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bra_byte_unit u_byte (
    .data       (cur_byte),
    .run_in     (run),
    .run_length (len_q),
    .res        (bres)
  );

  // registered read of the valid flags, aligned with ram data
  always_ff @(posedge clk) begin
    vld_q <= vld[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      byte_count  <= bra_pkg::RESET_BYTES;
      lowest_free <= 11'd0;
      free_total  <= {eff_bytes(bra_pkg::RESET_BYTES), 3'b000};
      vld         <= '0;
      rsp_valid   <= 1'b0;
      pvalid      <= 1'b0;
      ptr         <= 8'd0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      if (ram_we) begin
        vld[ram_addr] <= 1'b1;
      end

      // byte fetch pipeline for seek and scan
      if (state == S_SEEK || state == S_SCAN) begin
        if (ptr < used) begin
          ptr    <= ptr + 8'd1;
          pvalid <= 1'b1;
          pbyte  <= ptr;
        end else begin
          pvalid <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q    <= req_data.cmd;
            idx_q    <= req_data.bit_index;
            len_q    <= req_data.run_length;
            res_bval <= 1'b0;
            if (req_data.cmd == bra_pkg::CMD_SCAN) begin
              res_index <= 10'd0;
              if (req_data.run_length == 11'd0 || req_data.run_length > free_total) begin
                res_status <= bra_pkg::ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                run    <= 11'd0;
                pvalid <= 1'b1;
                pbyte  <= lowest_free[10:3];
                ptr    <= lowest_free[10:3] + 8'd1;
                state  <= S_SCAN;
              end
            end else if ({1'b0, req_data.bit_index} >= nbits) begin
              res_status <= bra_pkg::ST_RANGE;
              res_index  <= req_data.bit_index;
              state      <= S_DONE;
            end else begin
              state <= S_OP;
            end
          end
        end
        S_OP: begin
          res_index  <= idx_q;
          res_bval   <= cur_bit;
          res_status <= bra_pkg::ST_OK;
          state      <= S_DONE;
          case (cmd_q)
            bra_pkg::CMD_SET: begin
              if (cur_bit) begin
                res_status <= bra_pkg::ST_SAME;
              end else begin
                if (free_total != 11'd0) free_total <= free_total - 11'd1;
                if ({1'b0, idx_q} == lowest_free) begin
                  if (idx_inc == nbits) begin
                    lowest_free <= nbits;
                  end else begin
                    ptr    <= idx_inc[10:3];
                    pvalid <= 1'b0;
                    state  <= S_SEEK;
                  end
                end
              end
            end
            bra_pkg::CMD_CLEAR: begin
              if (!cur_bit) begin
                res_status <= bra_pkg::ST_SAME;
              end else begin
                if (free_total < nbits) free_total <= free_total + 11'd1;
                if ({1'b0, idx_q} < lowest_free) lowest_free <= {1'b0, idx_q};
              end
            end
            default: ;
          endcase
        end
        S_SEEK: begin
          // bits below the start are all taken, so whole bytes are searched
          if (pvalid && bres.zero_found) begin
            lowest_free <= {pbyte, bres.zero_pos};
            state       <= S_DONE;
          end else if (walk_end) begin
            lowest_free <= nbits;
            state       <= S_DONE;
          end
        end
        S_SCAN: begin
          if (pvalid) begin
            run <= bres.run_out;
          end
          if (pvalid && bres.run_found) begin
            res_status <= bra_pkg::ST_OK;
            res_index  <= scan_start[9:0];
            state      <= S_DONE;
          end else if (walk_end) begin
            res_status <= bra_pkg::ST_NOT_FOUND;
            res_index  <= 10'd0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid             <= 1'b1;
            rsp_data.status       <= res_status;
            rsp_data.result_index <= res_index;
            rsp_data.bit_value    <= res_bval;
            rsp_data.free_count   <= free_total;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // size write wipes the bitmap
      if (cfg_valid) begin
        byte_count  <= cfg_data;
        vld         <= '0;
        lowest_free <= 11'd0;
        free_total  <= {eff_bytes(cfg_data), 3'b000};
      end
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= nbits) else $error("free count above bitmap size");

  a_lowest_bound: assert property (@(posedge clk) disable iff (rst)
    lowest_free <= nbits) else $error("lowest free index past bitmap end");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEEK || state == S_SCAN) |-> ptr <= used)
    else $error("byte pointer past bitmap end");

endmodule
`default_nettype wire
